// ===== rtl/sslte_pkg.sv =====
package sslte_pkg;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  localparam logic [7:0] IC_MVN  = 8'hD1;
  localparam logic [7:0] IC_MVZ  = 8'hD3;
  localparam logic [7:0] IC_NC   = 8'hD4;
  localparam logic [7:0] IC_OC   = 8'hD6;
  localparam logic [7:0] IC_XC   = 8'hD7;
  localparam logic [7:0] IC_TR   = 8'hDC;
  localparam logic [7:0] IC_TRT  = 8'hDD;
  localparam logic [7:0] IC_ED   = 8'hDE;
  localparam logic [7:0] IC_EDMK = 8'hDF;

  localparam logic [7:0] PAT_DS   = 8'h20;
  localparam logic [7:0] PAT_SS   = 8'h21;
  localparam logic [7:0] PAT_FS   = 8'h22;
  localparam logic [3:0] SGN_MINUS = 4'hD;
  localparam logic [3:0] SGN_ALT   = 4'hB;
  localparam logic [7:0] ZONE_F    = 8'hF0;

endpackage

// ===== rtl/ss_logical_translate_edit_unit_core.sv =====
// Sequence: store writes on acceptance, then S_DONE; load uses S_LOAD, S_DONE;
//   execute runs S_RDP, S_RDQ, S_WR per byte position (up to 256), then S_DONE.
// Throughput: one item at a time; the single-port byte memory sets the pace,
//   one read or one write per cycle.
// Reset: rst_n synchronous, active low; clears control state only. The byte
//   memory keeps its contents and needs no clearing pass.
module ss_logical_translate_edit_unit_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_instr_code,
  input  logic [7:0]  in_length_code,
  input  logic [23:0] in_first_address,
  input  logic [23:0] in_second_address,
  input  logic [23:0] in_byte_address,
  input  logic [7:0]  in_byte_data,
  input  logic [31:0] in_reg1_value,
  input  logic [31:0] in_reg2_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_cond_code,
  output logic        out_data_exception,
  output logic [31:0] out_reg1_result,
  output logic [31:0] out_reg2_result
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDP  = 3'd1;  // read first operand / pattern byte
  localparam logic [2:0] S_RDQ  = 3'd2;  // read second operand / table / source
  localparam logic [2:0] S_WR   = 3'd3;  // write result byte, advance
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata_r;
  logic       we;
  logic [23:0] maddr;
  logic [7:0]  wdata;

  // map a 24-bit address to a memory position; a power-of-two size just
  // drops the upper bits
  function automatic logic [AW-1:0] pos(input logic [23:0] a);
    logic [23:0] m;
    begin
      if ((MEM_BYTES & (MEM_BYTES - 1)) == 0) m = a;
      else m = a % 24'(MEM_BYTES);
      return m[AW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[pos(maddr)] <= wdata;
    rdata_r <= mem[pos(maddr)];
  end

  logic [2:0]  st_r, st_nxt;
  logic [7:0]  code_r;
  logic [8:0]  len_r;
  logic [8:0]  i_r, i_nxt;
  logic [23:0] a1_r, a2_r;
  logic [1:0]  opc_r;
  logic [31:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [1:0]  cc_r, cc_nxt;
  logic        dx_r, dx_nxt;
  logic [7:0]  rd_out_r, rd_out_nxt;
  logic [7:0]  pb_r, pb_nxt;       // first operand / pattern byte
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [3:0]  cf2_r, cf2_nxt;
  logic [7:0]  k_r, k_nxt;
  logic        sig_r, sig_nxt, sec_r, sec_nxt;
  logic        outv_r, outv_nxt;
  logic        qread_r, qread_nxt; // second read was issued

  logic [23:0] p_addr;
  logic        is_edit, is_log;
  assign p_addr  = a1_r + {15'd0, i_r};
  assign is_edit = (code_r == sslte_pkg::IC_ED) || (code_r == sslte_pkg::IC_EDMK);
  assign is_log  = (code_r == sslte_pkg::IC_NC) || (code_r == sslte_pkg::IC_OC) ||
                   (code_r == sslte_pkg::IC_XC);

  assign in_stall = (st_r != S_IDLE) || outv_r;

  // edit digit handling temporaries
  logic [3:0] dig;
  logic       sig_t, sec_t, pend_t, pend_off;
  logic [1:0] cc_t;
  logic [31:0] r1_t;
  logic [7:0] eres;
  logic [3:0] cf2_t;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; r1_nxt = r1_r; r2_nxt = r2_r;
    cc_nxt = cc_r; dx_nxt = dx_r; rd_out_nxt = rd_out_r; pb_nxt = pb_r;
    fill_nxt = fill_r; src_nxt = src_r; cf2_nxt = cf2_r;
    k_nxt = k_r; sig_nxt = sig_r; sec_nxt = sec_r; outv_nxt = outv_r;
    qread_nxt = qread_r;
    we = 1'b0; maddr = p_addr; wdata = 8'd0;
    dig = 4'd0; sig_t = sig_r; sec_t = sec_r; pend_t = 1'b0; pend_off = 1'b0;
    cc_t = cc_r; r1_t = r1_r; eres = 8'd0; cf2_t = cf2_r;
    if (outv_r && !out_stall) outv_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        maddr = in_byte_address;
        if (in_valid && !in_stall) begin
          i_nxt = 9'd0; r1_nxt = in_reg1_value; r2_nxt = in_reg2_value;
          cc_nxt = 2'd0; dx_nxt = 1'b0; rd_out_nxt = 8'd0; k_nxt = 8'd0;
          sig_nxt = 1'b0; sec_nxt = 1'b0; cf2_nxt = 4'd0;
          case (in_opcode)
            sslte_pkg::OP_STORE: begin
              we = 1'b1; wdata = in_byte_data; st_nxt = S_DONE;
            end
            sslte_pkg::OP_LOAD: st_nxt = S_LOAD;
            sslte_pkg::OP_EXEC: st_nxt = S_RDP;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        rd_out_nxt = rdata_r; st_nxt = S_DONE;
      end
      S_RDP: begin
        // issue read of first operand byte
        if (code_r inside {sslte_pkg::IC_MVN, sslte_pkg::IC_MVZ, sslte_pkg::IC_NC,
                           sslte_pkg::IC_OC, sslte_pkg::IC_XC, sslte_pkg::IC_TR,
                           sslte_pkg::IC_TRT, sslte_pkg::IC_ED, sslte_pkg::IC_EDMK}) begin
          st_nxt = S_RDQ;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_RDQ: begin
        // rdata_r holds the first byte; issue second read when needed
        pb_nxt = rdata_r; qread_nxt = 1'b0;
        if (code_r == sslte_pkg::IC_TR || code_r == sslte_pkg::IC_TRT) begin
          maddr = a2_r + {16'd0, rdata_r}; qread_nxt = 1'b1;
        end else if (is_edit) begin
          if (i_r == 9'd0) fill_nxt = rdata_r;
          maddr = a2_r + {16'd0, k_r};
          qread_nxt = ((rdata_r == sslte_pkg::PAT_DS) || (rdata_r == sslte_pkg::PAT_SS))
                      && !sec_r;
        end else begin
          maddr = a2_r + {15'd0, i_r}; qread_nxt = 1'b1;
        end
        st_nxt = S_WR;
      end
      S_WR: begin
        // compute, write and advance
        st_nxt = S_RDP;
        i_nxt = i_r + 9'd1;
        if (i_nxt == len_r) st_nxt = S_DONE;
        if (is_edit) begin
          if ((pb_r == sslte_pkg::PAT_DS) || (pb_r == sslte_pkg::PAT_SS)) begin
            if (pb_r == sslte_pkg::PAT_SS) sig_t = 1'b1;
            if (qread_r) begin
              dig = rdata_r[7:4];
              cf2_t = rdata_r[3:0];
              src_nxt = rdata_r;
              sec_t = 1'b1;
              if (rdata_r[3:0] > 4'd9) begin
                pend_t = 1'b1;
                pend_off = !((rdata_r[3:0] == sslte_pkg::SGN_MINUS) ||
                             (rdata_r[3:0] == sslte_pkg::SGN_ALT));
                sec_t = 1'b0;
              end
            end else begin
              dig = src_r[3:0]; sec_t = 1'b0;
            end
            if (pb_r == sslte_pkg::PAT_DS && !sig_r) begin
              if (dig == 4'd0) eres = fill_r;
              else begin
                sig_t = 1'b1; cc_t = 2'd2; eres = sslte_pkg::ZONE_F | {4'd0, dig};
                if (code_r == sslte_pkg::IC_EDMK) r1_t = {r1_r[31:24], p_addr};
              end
            end else begin
              eres = sslte_pkg::ZONE_F | {4'd0, dig};
              if (dig != 4'd0) cc_t = 2'd2;
              if (pb_r == sslte_pkg::PAT_SS && code_r == sslte_pkg::IC_EDMK)
                r1_t = {r1_r[31:24], p_addr};
            end
            if (pend_t && pend_off) sig_t = 1'b0;
            if (qread_r && rdata_r[7:4] > 4'd9) begin
              // invalid left digit: abort without writing
              dx_nxt = 1'b1; st_nxt = S_DONE;
            end else begin
              we = 1'b1; wdata = eres; sig_nxt = sig_t; sec_nxt = sec_t;
              cf2_nxt = cf2_t; r1_nxt = r1_t;
              if (qread_r) k_nxt = k_r + 8'd1;
              if (i_nxt == len_r && cc_t != 2'd0 &&
                  (cf2_t == sslte_pkg::SGN_MINUS || cf2_t == sslte_pkg::SGN_ALT))
                cc_t = 2'd1;
              cc_nxt = cc_t;
            end
          end else begin
            if (pb_r == sslte_pkg::PAT_FS) begin
              sig_nxt = 1'b0; cc_t = 2'd0; eres = fill_r;
            end else begin
              eres = sig_r ? pb_r : fill_r;
            end
            we = 1'b1; wdata = eres;
            if (i_nxt == len_r && cc_t != 2'd0 &&
                (cf2_r == sslte_pkg::SGN_MINUS || cf2_r == sslte_pkg::SGN_ALT))
              cc_t = 2'd1;
            cc_nxt = cc_t;
          end
        end else if (code_r == sslte_pkg::IC_TRT) begin
          if (rdata_r != 8'd0) begin
            r1_nxt = {r1_r[31:24], p_addr};
            r2_nxt = {r2_r[31:8], rdata_r};
            cc_nxt = (i_nxt == len_r) ? 2'd2 : 2'd1;
            st_nxt = S_DONE;
          end
        end else begin
          we = 1'b1;
          case (code_r)
            sslte_pkg::IC_MVN: wdata = {pb_r[7:4], rdata_r[3:0]};
            sslte_pkg::IC_MVZ: wdata = {rdata_r[7:4], pb_r[3:0]};
            sslte_pkg::IC_NC:  wdata = pb_r & rdata_r;
            sslte_pkg::IC_OC:  wdata = pb_r | rdata_r;
            sslte_pkg::IC_XC:  wdata = pb_r ^ rdata_r;
            default:           wdata = rdata_r;
          endcase
          if (is_log && wdata != 8'd0) cc_nxt = 2'd1;
        end
      end
      S_DONE: begin
        outv_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid && !in_stall) begin
      code_r <= in_instr_code; len_r <= {1'b0, in_length_code} + 9'd1;
      a1_r <= in_first_address; a2_r <= in_second_address;
      opc_r <= in_opcode;
    end
    i_r <= i_nxt; r1_r <= r1_nxt; r2_r <= r2_nxt; cc_r <= cc_nxt; dx_r <= dx_nxt;
    rd_out_r <= rd_out_nxt; pb_r <= pb_nxt; fill_r <= fill_nxt;
    src_r <= src_nxt; cf2_r <= cf2_nxt; k_r <= k_nxt; sig_r <= sig_nxt;
    sec_r <= sec_nxt; qread_r <= qread_nxt;
  end

  assign out_valid          = outv_r;
  assign out_read_data      = rd_out_r;
  assign out_cond_code      = cc_r;
  assign out_data_exception = dx_r;
  assign out_reg1_result    = r1_r;
  assign out_reg2_result    = r2_r;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid) else $error("result not presented");
  a_dx_only_edit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_exception) |-> (opc_r == sslte_pkg::OP_EXEC))
    else $error("exception outside execute");
  a_load_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && opc_r != sslte_pkg::OP_LOAD) |-> (out_read_data == 8'd0))
    else $error("read data on non-load");
`endif

endmodule
